>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, codes and constants for the text console writer block.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry of the character screen.
    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    // Stream payload widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_PROMPT_WIDTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_ATTR    = 1'd1;

    localparam logic [6:0] RESET_PROMPT_WIDTH = 7'd4;
    localparam logic [7:0] RESET_TEXT_ATTR    = 8'h0F;

    // Character codes.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } tcw_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_READ,
        ST_READ_DATA,
        ST_PUT,
        ST_FILL,
        ST_WRITE,
        ST_UPDATE,
        ST_DONE
    } tcw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_issue;
        logic rd_capture;
        logic fill_write;
        logic row_validate;
        logic cell_write;
        logic cursor_update;
        logic wipe_all;
        logic result_load;
    } tcw_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       read_in_range;
        logic       wr_need;
        logic       row_valid;
        logic       fill_last;
    } tcw_status_t;

endpackage

>>> sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences one request at a time through the datapath and owns the
// handshake state of both stream channels.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  tcw_status_t status,
    output tcw_ctrl_t   ctrl
);

    tcw_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (status.cmd)
                    CMD_PUT:   state_next = ST_PUT;
                    CMD_READ:  state_next = status.read_in_range ? ST_DIV : ST_DONE;
                    CMD_CLEAR: state_next = ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_DIV:       state_next = ST_READ;
            ST_READ:      state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_DONE;
            ST_PUT: begin
                if (!status.wr_need) begin
                    state_next = ST_UPDATE;
                end else if (status.row_valid) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (status.fill_last) state_next = ST_WRITE;
            end
            ST_WRITE:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl          = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_DISPATCH: begin
                ctrl.wipe_all = (status.cmd == CMD_CLEAR);
            end
            ST_DIV:       ctrl.div_step = 1'b1;
            ST_READ:      ctrl.rd_issue = 1'b1;
            ST_READ_DATA: ctrl.rd_capture = 1'b1;
            ST_FILL: begin
                ctrl.fill_write   = 1'b1;
                ctrl.row_validate = status.fill_last;
            end
            ST_WRITE:  ctrl.cell_write = 1'b1;
            ST_UPDATE: ctrl.cursor_update = 1'b1;
            ST_DONE: begin
                ctrl.result_load = out_free;
                if (out_free) m_tvalid_next = 1'b1;
            end
            default: ctrl = '0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory with a rotating row origin, per-row blank tracking, the
// cursor, the configuration registers and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  tcw_ctrl_t             ctrl,
    output tcw_status_t           status,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int NCELLS = COLUMNS * ROWS;
    localparam int AW     = $clog2(NCELLS);

    // The row of a read is cell_index / COLUMNS by a reciprocal multiply.
    // The shift is wide enough that the quotient is exact for every 11-bit
    // index and every allowed column count.
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP       = (2**RECIP_SHIFT + COLUMNS - 1) / COLUMNS;
    localparam int PROD_W      = RECIP_SHIFT + RW + 1;

    // Request registers.
    logic [1:0]  cmd_reg;
    logic [7:0]  char_reg;
    logic [10:0] cell_reg;
    logic [RW-1:0] qrow_reg;

    // Configuration.
    logic [6:0] prompt_width_reg;
    logic [7:0] text_attr_reg;

    // Cursor and screen bookkeeping.
    logic [CW-1:0]   cur_col_reg;
    logic [RW-1:0]   cur_row_reg;
    logic [RW-1:0]   top_reg;
    logic [ROWS-1:0] row_valid_reg;
    logic [ROWS-1:0] row_scr_reg;
    logic [7:0]      row_attr_reg [ROWS];
    logic [7:0]      clear_attr_reg;
    logic [CW-1:0]   fill_col_reg;

    // Result fields.
    logic [7:0]  cell_char_reg;
    logic [7:0]  cell_attr_reg;
    logic        scrolled_reg;
    logic [M_TDATA_W-1:0] res_reg;

    logic [15:0] mem [NCELLS];
    logic [15:0] mem_q_reg;

    // Put evaluation.
    logic          is_nl, is_bs, bs_ok;
    logic [CW:0]   step_col;
    logic [RW:0]   step_row;
    logic          wr_need, scroll;
    logic [CW-1:0] wr_col, next_col;
    logic [RW-1:0] wr_row, next_row;
    logic [15:0]   wr_data;

    logic [RW-1:0] rd_phys, wr_phys, sel_phys;
    logic          sel_valid;
    logic [7:0]    sel_blank_attr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          fill_last;
    logic [15:0]   pos_wide;
    logic [7:0]    row_wide;
    logic [PROD_W-1:0] quot_prod;
    logic [CW-1:0] rd_col;

    // Logical row to physical memory row, given the current top row.
    function automatic logic [RW-1:0] phys_of(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] top);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (RW+1)'(ROWS)) sum = sum - (RW+1)'(ROWS);
        return sum[RW-1:0];
    endfunction

    always_comb begin
        is_nl    = (char_reg == CH_NEWLINE);
        is_bs    = (char_reg == CH_BACKSPACE);
        bs_ok    = (8'(cur_col_reg) > 8'(prompt_width_reg)) || (cur_row_reg != '0);
        step_col = {1'b0, cur_col_reg};
        step_row = {1'b0, cur_row_reg};
        wr_need  = 1'b0;
        wr_data  = {text_attr_reg, char_reg};
        if (is_nl) begin
            step_col = '0;
            step_row = step_row + 1'b1;
        end else if (is_bs) begin
            if (bs_ok) begin
                wr_need = 1'b1;
                wr_data = {text_attr_reg, CH_SPACE};
                if (cur_col_reg != '0) begin
                    step_col = step_col - 1'b1;
                end else begin
                    step_row = step_row - 1'b1;
                    step_col = (CW+1)'(COLUMNS - 1);
                end
            end
        end else begin
            wr_need  = 1'b1;
            step_col = step_col + 1'b1;
        end
        // Backspace targets the cell it stepped back onto; a character
        // targets the cell under the cursor.
        if (is_bs) begin
            wr_col = step_col[CW-1:0];
            wr_row = step_row[RW-1:0];
        end else begin
            wr_col = cur_col_reg;
            wr_row = cur_row_reg;
        end
        if (step_col == (CW+1)'(COLUMNS)) begin
            step_col = '0;
            step_row = step_row + 1'b1;
        end
        scroll   = (step_row == (RW+1)'(ROWS));
        next_col = step_col[CW-1:0];
        next_row = scroll ? RW'(ROWS - 1) : step_row[RW-1:0];
    end

    assign quot_prod = PROD_W'(cell_reg) * PROD_W'(RECIP);
    assign rd_col    = CW'(cell_reg - 11'(qrow_reg) * 11'(COLUMNS));

    assign rd_phys        = phys_of(qrow_reg, top_reg);
    assign wr_phys        = phys_of(wr_row, top_reg);
    assign sel_phys       = (cmd_reg == CMD_READ) ? rd_phys : wr_phys;
    assign sel_valid      = row_valid_reg[sel_phys];
    assign sel_blank_attr = row_scr_reg[sel_phys] ? row_attr_reg[sel_phys] : clear_attr_reg;
    assign fill_last      = (fill_col_reg == CW'(COLUMNS - 1));

    assign rd_addr = AW'(rd_phys) * AW'(COLUMNS) + AW'(rd_col);
    assign wr_addr = AW'(wr_phys) * AW'(COLUMNS)
                   + AW'(ctrl.fill_write ? fill_col_reg : wr_col);

    assign pos_wide = 16'(cur_row_reg) * 16'(COLUMNS) + 16'(cur_col_reg);
    assign row_wide = 8'(cur_row_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.fill_write || ctrl.cell_write) begin
            mem[wr_addr] <= ctrl.fill_write ? {sel_blank_attr, CH_SPACE} : wr_data;
        end
        if (ctrl.rd_issue) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prompt_width_reg <= RESET_PROMPT_WIDTH;
            text_attr_reg    <= RESET_TEXT_ATTR;
            clear_attr_reg   <= RESET_TEXT_ATTR;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            top_reg          <= '0;
            row_valid_reg    <= '0;
            row_scr_reg      <= '0;
            fill_col_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PROMPT_WIDTH: prompt_width_reg <= cfg_wdata[6:0];
                    REG_TEXT_ATTR:    text_attr_reg    <= cfg_wdata;
                    default:          text_attr_reg    <= text_attr_reg;
                endcase
            end
            if (ctrl.wipe_all) begin
                row_valid_reg  <= '0;
                row_scr_reg    <= '0;
                clear_attr_reg <= text_attr_reg;
                cur_col_reg    <= '0;
                cur_row_reg    <= '0;
            end
            if (ctrl.fill_write) begin
                fill_col_reg <= fill_last ? '0 : fill_col_reg + 1'b1;
            end
            if (ctrl.row_validate) begin
                row_valid_reg[wr_phys] <= 1'b1;
            end
            if (ctrl.cursor_update) begin
                cur_col_reg <= next_col;
                cur_row_reg <= next_row;
                if (scroll) begin
                    // The old top row becomes the blank bottom row.
                    row_valid_reg[top_reg] <= 1'b0;
                    row_scr_reg[top_reg]   <= 1'b1;
                    top_reg <= (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg       <= s_tuser;
            char_reg      <= s_tdata[7:0];
            cell_reg      <= s_tdata[18:8];
            qrow_reg      <= '0;
            cell_char_reg <= '0;
            cell_attr_reg <= '0;
            scrolled_reg  <= 1'b0;
        end
        if (ctrl.div_step) begin
            qrow_reg <= quot_prod[RECIP_SHIFT +: RW];
        end
        if (ctrl.cursor_update) begin
            scrolled_reg <= scroll;
            if (scroll) row_attr_reg[top_reg] <= text_attr_reg;
        end
        if (ctrl.rd_capture) begin
            if (sel_valid) begin
                cell_char_reg <= mem_q_reg[7:0];
                cell_attr_reg <= mem_q_reg[15:8];
            end else begin
                cell_char_reg <= CH_SPACE;
                cell_attr_reg <= sel_blank_attr;
            end
        end
        if (ctrl.result_load) begin
            res_reg <= {scrolled_reg, cell_attr_reg, cell_char_reg, pos_wide[10:0],
                        row_wide[4:0], 7'(cur_col_reg)};
        end
    end

    assign status.cmd           = cmd_reg;
    assign status.read_in_range = (14'(cell_reg) < 14'(NCELLS));
    assign status.wr_need       = wr_need;
    assign status.row_valid     = sel_valid;
    assign status.fill_last     = fill_last;

    assign m_tdata = res_reg;

endmodule

>>> sv/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console writer unit
// Character-cell console: put, read and clear requests over a stream port.
// ----------------------------------------------------------------------------
// Steps, accepting edge to result load: dispatch; for a put, the put state,
//   a blank rewrite of its row if needed, the cell write if any and the
//   cursor update; for a read in range, the row division, memory read and
//   capture; no more for other requests. A stalled earlier result delays
//   the load. One request in flight; the next is accepted in the cycle after
//   the result load. Reset: synchronous, active low; the screen reads as
//   blanks with attribute 0x0F at once, with no clearing pass; cursor home.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: char_code [7:0], cell_index [18:8], zero fill [23:19].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: cmd [1:0] (put, read, clear).
    input  logic [S_TUSER_W-1:0]  s_tuser,

    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: cursor_col [6:0], cursor_row [11:7], cursor_pos [22:12],
    //        cell_char [30:23], cell_attr [38:31], scrolled [39].
    output logic [M_TDATA_W-1:0]  m_tdata,

    // Configuration writes: index 0 prompt_width, index 1 text_attr.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // The controller steps each request through dispatch, the row division
    // for reads, the optional row rewrite and the cell write; the datapath
    // holds all storage and answers with status flags.
    tcw_ctrl_t   ctrl;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // Scrolling rotates the row origin instead of moving cells, and rows
    // blanked by a scroll or a clear are tracked by per-row flags; such a
    // row is rewritten with blanks only when a cell in it is next written.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

>>> sv/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one request is worked on at a time.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // The cursor column stays on the screen.
    a_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] < 7'(COLUMNS - 1) || m_tdata[6:0] == 7'(COLUMNS - 1))
        else $error("cursor column off screen");

    // A scroll leaves the cursor at the start of the bottom row.
    a_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39] |-> m_tdata[6:0] == 7'd0
                                  && m_tdata[11:7] == 5'(ROWS - 1))
        else $error("scroll with cursor not at bottom row start");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, read, clear and unused requests over the request stream, with
// random gaps on the sender side and random stalls on the result side. A
// shadow copy of the screen, the cursor and both registers predicts every
// result, and each returned result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb
    import tcw_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = DEFAULT_COLUMNS;
    localparam int ROWS    = DEFAULT_ROWS;
    localparam int NCELLS  = COLUMNS * ROWS;

    // The request kind that the block has no use for. It must change nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Longest stretch without any accepted request or result. It covers
    // the slowest request (a put that first rewrites a blanked row) plus a
    // sender gap and a receiver stall.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet time after the last result, to catch a stray extra result.
    localparam int TAIL_CYCLES    = 300;

    localparam int PHASES          = 7;
    localparam int PHASE_REQUESTS  = 245;

    // One result, laid out exactly as the block packs m_tdata (MSB first).
    typedef struct packed {
        logic       scrolled;
        logic [7:0] cell_attr;
        logic [7:0] cell_char;
        logic [10:0] cursor_pos;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } console_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own screen, cursor and registers, works out the
    // result of every accepted request and checks results in arrival order.
    // ------------------------------------------------------------------------
    class console_scoreboard;
        logic [15:0]     screen [NCELLS];
        int              col;
        int              row;
        logic [6:0]      prompt_width;
        logic [7:0]      text_attr;
        console_result_t expected_results [$];
        int              failures;

        function new();
            prompt_width = RESET_PROMPT_WIDTH;
            text_attr    = RESET_TEXT_ATTR;
            col          = 0;
            row          = 0;
            failures     = 0;
            blank_screen();
        endfunction

        function logic [15:0] blank_cell();
            return {text_attr, CH_SPACE};
        endfunction

        function void blank_screen();
            int i;
            for (i = 0; i < NCELLS; i++) screen[i] = blank_cell();
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] addr,
                                     logic [CFG_DATA_W-1:0] data);
            if (addr == REG_PROMPT_WIDTH) prompt_width = data[6:0];
            else if (addr == REG_TEXT_ATTR) text_attr = data;
        endfunction

        // Applies one accepted request to the shadow state and queues the
        // result that the block has to return for it.
        function void note_request(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
            console_result_t res;
            int i;
            res = '0;
            case (cmd)
                CMD_PUT: begin
                    if (ch == CH_NEWLINE) begin
                        col = 0;
                        row++;
                    end else if (ch == CH_BACKSPACE) begin
                        // On row zero the cursor may not back into the prompt.
                        // At column zero the condition implies row > 0.
                        if (col > prompt_width || row > 0) begin
                            if (col > 0) begin
                                col--;
                            end else begin
                                row--;
                                col = COLUMNS - 1;
                            end
                            screen[row * COLUMNS + col] = blank_cell();
                        end
                    end else begin
                        screen[row * COLUMNS + col] = {text_attr, ch};
                        col++;
                    end
                    if (col >= COLUMNS) begin
                        col = 0;
                        row++;
                    end
                    if (row >= ROWS) begin
                        for (i = 0; i < NCELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                        for (i = NCELLS - COLUMNS; i < NCELLS; i++) screen[i] = blank_cell();
                        row = ROWS - 1;
                        res.scrolled = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (idx < NCELLS) begin
                        res.cell_char = screen[idx][7:0];
                        res.cell_attr = screen[idx][15:8];
                    end
                end
                CMD_CLEAR: begin
                    blank_screen();
                    col = 0;
                    row = 0;
                end
                default: begin
                end
            endcase
            res.cursor_col = 7'(col);
            res.cursor_row = 5'(row);
            res.cursor_pos = 11'(row * COLUMNS + col);
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $realtime, name, expected, actual);
                failures++;
            end
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending: actual %h", $realtime, got);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
            compare_field("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
            compare_field("cursor_pos", int'(want.cursor_pos), int'(got.cursor_pos));
            compare_field("cell_char", int'(want.cell_char), int'(got.cell_char));
            compare_field("cell_attr", int'(want.cell_attr), int'(got.cell_attr));
            compare_field("scrolled", int'(want.scrolled), int'(got.scrolled));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value; the test drives them at the falling edge only.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // 0: no idling, 1: occasional gaps and stalls, 2: frequent ones.
    int idle_level = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    console_scoreboard tracker = new();

    always #5 aclk = ~aclk;

    text_console_writer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Result side: ready is dropped low in random bursts, so stalls land
    // on every stage of the block's work.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_level != 0 &&
                     $urandom_range(0, (idle_level == 1) ? 11 : 2) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor at the rising edge: register writes and accepted requests go
    // into the scoreboard, accepted results are checked. A request is noted
    // before a result of the same edge, but the queue keeps the older one at
    // its head, so the pairing stays right. The watchdog runs here too.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) tracker.write_register(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready) tracker.note_request(s_tuser, s_tdata[7:0], s_tdata[18:8]);
            if (m_tvalid && m_tready) tracker.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results still expected",
                         $realtime, tracker.pending());
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Presents one request and returns at the falling edge after it has been
    // accepted, with valid still high. The next call either keeps valid up
    // with new contents or opens a gap; either way valid gets one assignment
    // per time step.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [10:0] idx);
        int gap;
        gap = 0;
        if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 11 : 2) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, idx, ch};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes both registers, prompt width first, in back-to-back cycles. Only called while
    // nothing is in flight.
    task automatic set_console_config(input logic [6:0] prompt, input logic [7:0] attr);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PROMPT_WIDTH;
        cfg_wdata <= {1'b0, prompt};
        @(negedge aclk);
        cfg_addr  <= REG_TEXT_ATTR;
        cfg_wdata <= attr;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random requests, weighted toward text output so that the cursor wraps
    // and the screen scrolls often. Runs of backspaces walk back across row
    // boundaries up to the prompt, and runs of newlines reach the bottom row
    // quickly. Fields a request does not use carry random values.
    task automatic send_random_requests(input int count);
        int left;
        int pick;
        int run;
        int base;
        int n;
        logic [7:0] ch;
        logic [10:0] idx;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 399);
            ch   = 8'($urandom);
            idx  = 11'($urandom);
            run  = 1;
            if (pick < 230) begin
                send_request(CMD_PUT, 8'($urandom_range(32, 126)), idx);
            end else if (pick < 270) begin
                send_request(CMD_PUT, CH_NEWLINE, idx);
            end else if (pick < 306) begin
                send_request(CMD_PUT, CH_BACKSPACE, idx);
            end else if (pick < 316) begin
                run = (pick < 312) ? $urandom_range(10, 90) : $urandom_range(5, 30);
                if (run > left) run = left;
                repeat (run)
                    send_request(CMD_PUT, (pick < 312) ? CH_BACKSPACE : CH_NEWLINE, 11'($urandom));
            end else if (pick < 336) begin
                send_request(CMD_PUT, ch, idx);
            end else if (pick < 388) begin
                // Half the reads look just behind the cursor, where the
                // latest text sits; some go anywhere, a few past the end.
                n = $urandom_range(0, 9);
                if (n < 5) begin
                    base = tracker.row * COLUMNS + tracker.col;
                    idx  = 11'(base - $urandom_range(0, (base < 160) ? base : 160));
                end else if (n < 9) begin
                    idx = 11'($urandom_range(0, NCELLS - 1));
                end else begin
                    idx = 11'($urandom_range(NCELLS - 10, 2047));
                end
                send_request(CMD_READ, ch, idx);
            end else if (pick < 398) begin
                send_request(CMD_UNUSED, ch, idx);
            end else begin
                send_request(CMD_CLEAR, ch, idx);
            end
            left -= run;
        end
    endtask

    initial begin
        int phase;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings (prompt 4, attribute 0x0F).
        // The screen must read as blanks right after reset, and a read past
        // the last cell returns zeros.
        send_request(CMD_READ, 8'hFF, 11'd0);
        send_request(CMD_READ, 8'h00, 11'(NCELLS - 1));
        send_request(CMD_READ, 8'h5A, 11'(NCELLS));
        // Backspace at the home position is blocked.
        send_request(CMD_PUT, CH_BACKSPACE, 11'h7FF);
        send_request(CMD_PUT, 8'h00, 11'd0);
        send_request(CMD_PUT, 8'hFF, 11'd0);
        send_request(CMD_PUT, "A", 11'd0);
        // Column 3 is still inside the prompt, so this one is blocked too.
        send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
        send_request(CMD_PUT, "B", 11'd0);
        send_request(CMD_PUT, "C", 11'd0);
        // Column 5 is past the prompt: steps back and blanks column 4.
        send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
        send_request(CMD_READ, 8'd0, 11'd4);
        // Backspace from column 0 of row 1 wraps to the last column of row 0;
        // a character there wraps the cursor back onto row 1.
        send_request(CMD_PUT, CH_NEWLINE, 11'd0);
        send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
        send_request(CMD_READ, 8'd0, 11'(COLUMNS - 1));
        send_request(CMD_PUT, "Z", 11'd0);
        send_request(CMD_READ, 8'd0, 11'd1);
        // The unused request kind leaves everything as it was.
        send_request(CMD_UNUSED, 8'hA5, 11'h555);
        send_request(CMD_CLEAR, 8'h3C, 11'h2AA);
        send_request(CMD_READ, 8'd0, 11'd1);

        // Zero prompt and zero attribute: backspace at home is still
        // blocked, one step past it is not, and the blank takes attribute 0.
        wait_for_results();
        set_console_config(7'd0, 8'h00);
        send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
        send_request(CMD_PUT, "q", 11'd0);
        send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
        send_request(CMD_READ, 8'd0, 11'd0);

        // Random phases. Each one starts from an idle block with fresh
        // settings: first the extremes, then the reset values, then random
        // ones. The sender always pauses until every result is back before
        // the next phase, and the last phase runs without any idling.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            case (phase)
                0: set_console_config(7'd0, 8'h00);
                1: set_console_config(7'd79, 8'hFF);
                2: set_console_config(RESET_PROMPT_WIDTH, RESET_TEXT_ATTR);
                default: set_console_config(7'($urandom_range(0, 79)), 8'($urandom));
            endcase
            case (phase)
                0, 4: idle_level = 1;
                1, 3, 5: idle_level = 2;
                default: idle_level = 0;
            endcase
            send_random_requests(PHASE_REQUESTS);
        end

        idle_level = 0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer_unit.sv
sv/tcw_checker.sv
bench/tb.sv
